>>> rtl/core/brl_pkg.sv
// shared types and constants for the bresenham line rasterizer
// holds the command record passed from setup to stepper; no dependencies
package brl_pkg;

  localparam int CANVAS_SIDE = 64;
  localparam int COORD_W     = $clog2(CANVAS_SIDE);
  localparam int CANVAS_W    = COORD_W + 1;
  localparam int COLOR_W     = 8;
  // decision term spans about -2*major .. 2*minor
  localparam int DEC_W       = COORD_W + 3;
  localparam int IN_DATA_W   = 4 * COORD_W + COLOR_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * COORD_W + COLOR_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W  = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic               x_neg;
    logic               y_neg;
    logic               x_major;
    logic [DEC_W-1:0]   d;
    logic [DEC_W-1:0]   inc_flat;
    logic [DEC_W-1:0]   inc_diag;
    logic [COORD_W-1:0] remain;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage

>>> rtl/core/brl_setup.sv
// front end: unpacks a line command and works out the stepping setup
// depends on brl_pkg
module brl_setup (
  input  logic [brl_pkg::IN_TDATA_W-1:0] in_word,
  output brl_pkg::cmd_t                  cmd
);
  import brl_pkg::*;

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic [COLOR_W-1:0] color;
  logic [COORD_W-1:0] dx, dy, major, minor;
  logic               x_neg, y_neg, x_major;
  logic [DEC_W-1:0]   minor2, major_ext;

  always_comb begin
    x0    = in_word[COORD_W-1:0];
    y0    = in_word[2*COORD_W-1:COORD_W];
    x1    = in_word[3*COORD_W-1:2*COORD_W];
    y1    = in_word[4*COORD_W-1:3*COORD_W];
    color = in_word[4*COORD_W+COLOR_W-1:4*COORD_W];

    x_neg   = x1 < x0;
    y_neg   = y1 < y0;
    dx      = x_neg ? (x0 - x1) : (x1 - x0);
    dy      = y_neg ? (y0 - y1) : (y1 - y0);
    x_major = dy <= dx;
    major   = x_major ? dx : dy;
    minor   = x_major ? dy : dx;

    minor2    = {2'b00, minor, 1'b0};
    major_ext = {3'b000, major};

    cmd.x0       = x0;
    cmd.y0       = y0;
    cmd.x_neg    = x_neg;
    cmd.y_neg    = y_neg;
    cmd.x_major  = x_major;
    cmd.d        = minor2 - major_ext;
    cmd.inc_flat = minor2;
    cmd.inc_diag = minor2 - {major_ext[DEC_W-2:0], 1'b0};
    // run holds major+1 pixels, never more than the canvas side
    cmd.remain   = major;
    cmd.color    = color;
  end

endmodule

>>> rtl/core/brl_queue.sv
// short command queue between setup and stepper
// depends on brl_pkg
module brl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  brl_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output brl_pkg::cmd_t head_cmd
);
  import brl_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({push && !full, pop && !empty})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/brl_stepper.sv
// back end: walks one line a pixel per cycle, while the output slot is free, into an output register
// depends on brl_pkg
module brl_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  brl_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic [brl_pkg::CANVAS_W-1:0]  canvas_width,
  input  logic [brl_pkg::CANVAS_W-1:0]  canvas_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brl_pkg::COORD_W-1:0]  out_x,
  output logic [brl_pkg::COORD_W-1:0]  out_y,
  output logic [brl_pkg::COLOR_W-1:0]  out_color,
  output logic                          out_visible,
  output logic                          out_last
);
  import brl_pkg::*;

  logic               busy_r, busy_nxt;
  cmd_t               cur_r, cur_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [COLOR_W-1:0] ocolor_r;
  logic               ovis_r, olast_r;
  logic               slot_free, emit;
  logic               step_diag;

  assign slot_free = !ovalid_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign q_pop     = !busy_r && !q_empty;
  assign step_diag = $signed(cur_r.d) > 0;

  always_comb begin
    busy_nxt   = busy_r;
    cur_nxt    = cur_r;
    ovalid_nxt = ovalid_r && !out_ready;
    if (q_pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = q_cmd;
    end else if (emit) begin
      ovalid_nxt = 1'b1;
      if (cur_r.remain == '0) begin
        busy_nxt = 1'b0;
      end
      cur_nxt.remain = cur_r.remain - 1'b1;
      cur_nxt.d      = cur_r.d + (step_diag ? cur_r.inc_diag : cur_r.inc_flat);
      // major axis always steps, minor only on a diagonal move
      if (cur_r.x_major || step_diag) begin
        cur_nxt.x0 = cur_r.x_neg ? cur_r.x0 - 1'b1 : cur_r.x0 + 1'b1;
      end
      if (!cur_r.x_major || step_diag) begin
        cur_nxt.y0 = cur_r.y_neg ? cur_r.y0 - 1'b1 : cur_r.y0 + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      ox_r     <= cur_r.x0;
      oy_r     <= cur_r.y0;
      ocolor_r <= cur_r.color;
      ovis_r   <= ({1'b0, cur_r.x0} < canvas_width) && ({1'b0, cur_r.y0} < canvas_height);
      olast_r  <= cur_r.remain == '0;
    end
  end

  assign out_valid   = ovalid_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;
  assign out_color   = ocolor_r;
  assign out_visible = ovis_r;
  assign out_last    = olast_r;

endmodule

>>> rtl/core/bresenham_line_rasterizer.sv
// Bresenham line rasterizer, top level
// Use: each word on the in_ stream is one line command (two endpoints and a
// pen color). The block answers with the pixel run from start to end on the
// out_ stream, one word per pixel, the final pixel flagged by out_tlast and
// every pixel flagged visible in out_tuser when it lies inside the canvas.
// The canvas size is set through the cfg_ write port (index 0 width,
// index 1 height); the user must write it only while no line is in
// flight, which the block itself does not enforce. Both reset to zero, so
// every pixel reads invisible until written.
// Flow: a command moves from the queue to the stepper's command register once
// the previous line is done, then its max(|dx|,|dy|)+1 pixels stream into the
// output register at one pixel per cycle while the receiver takes them.
// A two-entry command queue lets new commands be taken while a line is drawn.
// When the receiver stalls, the output word holds and stepping pauses; the
// input side keeps taking commands until the queue fills.
// Reset (rst_n low, synchronous) empties the queue and drops any run.
// depends on brl_pkg, brl_setup, brl_queue, brl_stepper
module bresenham_line_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_x, start_y, end_x, end_y, pen_color
  input  logic [brl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [brl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // visible
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [brl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [brl_pkg::CANVAS_W-1:0]       cfg_wdata
);
  import brl_pkg::*;

  cmd_t               setup_cmd, head_cmd;
  logic               q_full, q_empty, q_pop;
  logic [CANVAS_W-1:0] canvas_width_r, canvas_height_r;
  logic [COORD_W-1:0] px, py;
  logic [COLOR_W-1:0] pcolor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= '0;
      canvas_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata;
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;

  brl_setup u_setup (
    .in_word (in_tdata),
    .cmd     (setup_cmd)
  );

  brl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_cmd (setup_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  brl_stepper u_stepper (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .canvas_width  (canvas_width_r),
    .canvas_height (canvas_height_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_x         (px),
    .out_y         (py),
    .out_color     (pcolor),
    .out_visible   (out_tuser),
    .out_last      (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}}, pcolor, py, px};

endmodule
